@@ rtl/core/pfts_pkg.sv @@
// shared types, constants and slice table for the priority feedback task scheduler
package pfts_pkg;

  localparam int MaxTasks   = 16;
  localparam int PrioLevels = 32;
  localparam int TaskW      = 4;
  localparam int PrioW      = 5;
  localparam int SliceW     = 5;
  localparam int BoostW     = 8;
  localparam int TickW      = 32;
  localparam int OpW        = 3;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;

  typedef logic [TaskW-1:0] task_id_t;
  typedef logic [PrioW-1:0] prio_t;
  typedef logic [TickW-1:0] tick_t;

  localparam prio_t PrioMax = prio_t'(PrioLevels - 1);

  // event codes
  localparam logic [OpW-1:0] OP_TICK  = 3'd0;
  localparam logic [OpW-1:0] OP_ADMIT = 3'd1;
  localparam logic [OpW-1:0] OP_WAKE  = 3'd2;
  localparam logic [OpW-1:0] OP_BLOCK = 3'd3;
  localparam logic [OpW-1:0] OP_YIELD = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_AGING_INTERVAL = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_AGING_STARVE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_AGING_CAP      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_AGING_SPAN     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DECAY_STEP     = 3'd4;

  typedef struct packed {
    logic [7:0]  interval;
    logic [15:0] starve;
    prio_t       cap;
    prio_t       span;
    prio_t       decay;
  } cfg_t;

  // time slice per priority band, zero means unlimited
  function automatic logic [SliceW-1:0] band_slice(input prio_t p);
    logic [SliceW-1:0] s;
    if (p == PrioMax) s = 5'd0;
    else if (p >= 5'd24) s = 5'd20;
    else if (p >= 5'd16) s = 5'd10;
    else if (p >= 5'd8) s = 5'd6;
    else if (p >= 5'd1) s = 5'd2;
    else s = 5'd1;
    return s;
  endfunction

endpackage

@@ rtl/core/priority_feedback_task_scheduler.sv @@
// top level of the priority feedback task scheduler: event sequencer and task tables
//
//   channel | direction | handshake          | payload
//   in_     | in        | in_valid/in_stall  | operation, task_id, priority_req, boost_count
//   out_    | out       | out_valid/out_stall| run_task, run_idle, switched, run_priority
//   cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one event at a time: a sequencer walks the task tables entry by entry
// an aging scan, when it fires, makes 16 task checks plus, per aged task, a queue
// unlink that walks the level's link chain (at most 16 entries) and a relink; the
// level pick scans down from the top level one level per cycle
// reset is synchronous; link, head and tail stores are not cleared, the queue
// discipline only reads entries it wrote
// a finished result sits in the output register while out_stall is high; the
// next event is taken as soon as the sequencer is back in idle
module priority_feedback_task_scheduler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pfts_pkg::OpW-1:0]        in_operation,
  input  logic [pfts_pkg::TaskW-1:0]      in_task_id,
  input  logic [pfts_pkg::PrioW-1:0]      in_priority_req,
  input  logic [pfts_pkg::BoostW-1:0]     in_boost_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pfts_pkg::TaskW-1:0]      out_run_task,
  output logic                            out_run_idle,
  output logic                            out_switched,
  output logic [pfts_pkg::PrioW-1:0]      out_run_priority,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pfts_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [pfts_pkg::CfgDataW-1:0]   cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_PUSH0, S_PUSH1, S_PULL0, S_PULL1, S_PULL2,
    S_AGE_CHK, S_AGE_T, S_AGE_INC, S_AGE_NEXT, S_QUANT, S_QUANT2,
    S_PICK_LV, S_PICK, S_PICK2, S_PICK3, S_REPORT
  } state_t;

  pfts_pkg::cfg_t cfg;

  pfts_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer registers
  state_t                       state_r, ret_r;
  logic [pfts_pkg::OpW-1:0]     op_r;
  pfts_pkg::prio_t              req_r;
  logic [pfts_pkg::BoostW-1:0]  bc_r;
  pfts_pkg::task_id_t           t_r;      // task under work
  pfts_pkg::prio_t              lv_r;     // level under work
  pfts_pkg::task_id_t           walk_r;   // link chain cursor
  pfts_pkg::task_id_t           lt_r;     // link of the task being unlinked
  logic [pfts_pkg::TaskW-1:0]   n_r;      // chain walk bound
  pfts_pkg::task_id_t           cur_task_r, prev_task_r;
  logic                         cur_valid_r, prev_valid_r, sw_r;
  pfts_pkg::tick_t              tick_r, aging_last_r;
  logic [pfts_pkg::PrioLevels-1:0] ready_mask_r;
  logic [pfts_pkg::MaxTasks-1:0]   ready_r;

  // per-task tables
  pfts_pkg::prio_t              prio_r  [pfts_pkg::MaxTasks];
  pfts_pkg::prio_t              base_r  [pfts_pkg::MaxTasks];
  logic [pfts_pkg::SliceW-1:0]  slice_r [pfts_pkg::MaxTasks];
  logic [pfts_pkg::BoostW-1:0]  boost_r [pfts_pkg::MaxTasks];
  pfts_pkg::tick_t              last_r  [pfts_pkg::MaxTasks];
  pfts_pkg::task_id_t           link_r  [pfts_pkg::MaxTasks];
  pfts_pkg::task_id_t           head_r  [pfts_pkg::PrioLevels];
  pfts_pkg::task_id_t           tail_r  [pfts_pkg::PrioLevels];

  // output register
  logic                         out_valid_r, out_idle_r, out_sw_r;
  pfts_pkg::task_id_t           out_task_r;
  pfts_pkg::prio_t              out_prio_r;

  // single read port per table, addressed by t_r or lv_r (the link table by walk_r or t_r)
  pfts_pkg::prio_t              t_prio, t_base;
  logic [pfts_pkg::SliceW-1:0]  t_slice, slice_dec;
  logic [pfts_pkg::BoostW-1:0]  t_boost;
  pfts_pkg::tick_t              t_last;
  logic                         t_ready, lv_bit;
  pfts_pkg::task_id_t           lv_head, lv_tail, link_rd, link_addr;
  logic [pfts_pkg::PrioW:0]     cap_sum;
  pfts_pkg::prio_t              age_cap, decay_sub, decay_prio;
  logic                         age_hit, age_due, id_free, same_task;

  always_comb begin
    t_prio    = prio_r[t_r];
    t_base    = base_r[t_r];
    t_slice   = slice_r[t_r];
    t_boost   = boost_r[t_r];
    t_last    = last_r[t_r];
    t_ready   = ready_r[t_r];
    lv_bit    = ready_mask_r[lv_r];
    lv_head   = head_r[lv_r];
    lv_tail   = tail_r[lv_r];
    link_addr = (state_r == S_PULL2) ? walk_r : t_r;
    link_rd   = link_r[link_addr];
    // aging limit: min(base + span, cap)
    cap_sum   = {1'b0, t_base} + {1'b0, cfg.span};
    age_cap   = (cap_sum > {1'b0, cfg.cap}) ? cfg.cap : cap_sum[pfts_pkg::PrioW-1:0];
    age_hit   = t_ready && (t_last != '0) &&
                ((tick_r - t_last) >= {16'd0, cfg.starve}) && (t_prio < age_cap);
    age_due   = (tick_r - aging_last_r) >= {24'd0, cfg.interval};
    slice_dec = (t_slice != '0) ? t_slice - 5'd1 : '0;
    decay_sub = (t_prio >= cfg.decay) ? t_prio - cfg.decay : '0;
    decay_prio = (decay_sub > t_base) ? decay_sub : t_base;
    id_free   = !(cur_valid_r && cur_task_r == t_r) && !t_ready;
    same_task = prev_valid_r && (prev_task_r == t_r);
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_run_task     = out_task_r;
  assign out_run_idle     = out_idle_r;
  assign out_switched     = out_sw_r;
  assign out_run_priority = out_prio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      cur_task_r   <= '0;
      cur_valid_r  <= 1'b0;
      tick_r       <= '0;
      aging_last_r <= '0;
      ready_mask_r <= '0;
      ready_r      <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < pfts_pkg::MaxTasks; i++) begin
        prio_r[i]  <= '0;
        base_r[i]  <= '0;
        slice_r[i] <= '0;
        boost_r[i] <= '0;
        last_r[i]  <= '0;
      end
    end else begin
      // the report step reloads the register itself when it is taken
      if (out_valid_r && !out_stall && state_r != S_REPORT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r         <= in_operation;
            req_r        <= in_priority_req;
            bc_r         <= in_boost_count;
            prev_valid_r <= cur_valid_r;
            prev_task_r  <= cur_task_r;
            if (in_operation == pfts_pkg::OP_BLOCK || in_operation == pfts_pkg::OP_YIELD)
              t_r <= cur_task_r;
            else
              t_r <= in_task_id;
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          ret_r <= S_AGE_CHK;
          case (op_r)
            pfts_pkg::OP_TICK: begin
              tick_r  <= tick_r + 32'd1;
              state_r <= S_AGE_CHK;
            end
            pfts_pkg::OP_ADMIT: begin
              if (id_free) begin
                base_r[t_r]  <= req_r;
                prio_r[t_r]  <= req_r;
                boost_r[t_r] <= '0;
                slice_r[t_r] <= '0;
                last_r[t_r]  <= '0;
                state_r      <= S_PUSH0;
              end else begin
                state_r <= S_AGE_CHK;
              end
            end
            pfts_pkg::OP_WAKE: begin
              if (id_free) begin
                if (bc_r != '0) begin
                  prio_r[t_r]  <= req_r;
                  boost_r[t_r] <= bc_r;
                end else begin
                  prio_r[t_r]  <= t_base;
                  boost_r[t_r] <= '0;
                end
                state_r <= S_PUSH0;
              end else begin
                state_r <= S_AGE_CHK;
              end
            end
            pfts_pkg::OP_BLOCK: begin
              cur_valid_r <= 1'b0;
              state_r     <= S_AGE_CHK;
            end
            pfts_pkg::OP_YIELD: begin
              if (cur_valid_r) begin
                slice_r[t_r] <= '0;
                if (t_prio == pfts_pkg::PrioMax) begin
                  // top priority goes straight back to its queue
                  cur_valid_r <= 1'b0;
                  state_r     <= S_PUSH0;
                end else begin
                  state_r <= S_AGE_CHK;
                end
              end else begin
                sw_r    <= 1'b0;
                state_r <= S_REPORT;
              end
            end
            default: begin
              // unknown event: report the running task unchanged
              sw_r    <= 1'b0;
              t_r     <= cur_task_r;
              state_r <= S_REPORT;
            end
          endcase
        end
        // append t_r to the tail of its level
        S_PUSH0: begin
          lv_r    <= t_prio;
          state_r <= S_PUSH1;
        end
        S_PUSH1: begin
          if (lv_bit) link_r[lv_tail] <= t_r;
          else head_r[lv_r] <= t_r;
          tail_r[lv_r]       <= t_r;
          ready_mask_r[lv_r] <= 1'b1;
          ready_r[t_r]       <= 1'b1;
          state_r            <= ret_r;
        end
        // unlink t_r from its level
        S_PULL0: begin
          lv_r    <= t_prio;
          lt_r    <= link_rd;
          n_r     <= '0;
          state_r <= S_PULL1;
        end
        S_PULL1: begin
          if (!lv_bit) begin
            ready_r[t_r] <= 1'b0;
            state_r      <= ret_r;
          end else if (lv_head == t_r) begin
            if (lv_tail == t_r) ready_mask_r[lv_r] <= 1'b0;
            else head_r[lv_r] <= lt_r;
            ready_r[t_r] <= 1'b0;
            state_r      <= ret_r;
          end else begin
            walk_r  <= lv_head;
            state_r <= S_PULL2;
          end
        end
        S_PULL2: begin
          if (link_rd == t_r) begin
            link_r[walk_r] <= lt_r;
            if (lv_tail == t_r) tail_r[lv_r] <= walk_r;
            ready_r[t_r] <= 1'b0;
            state_r      <= ret_r;
          end else if (walk_r == lv_tail ||
                       n_r == pfts_pkg::TaskW'(pfts_pkg::MaxTasks - 1)) begin
            ready_r[t_r] <= 1'b0;
            state_r      <= ret_r;
          end else begin
            walk_r <= link_rd;
            n_r    <= n_r + 4'd1;
          end
        end
        // starvation aging scan over all tasks, once the aging interval has elapsed
        S_AGE_CHK: begin
          if (age_due) begin
            aging_last_r <= tick_r;
            t_r          <= '0;
            state_r      <= S_AGE_T;
          end else begin
            t_r     <= cur_task_r;
            state_r <= S_QUANT;
          end
        end
        S_AGE_T: begin
          if (age_hit) begin
            ret_r   <= S_AGE_INC;
            state_r <= S_PULL0;
          end else begin
            state_r <= S_AGE_NEXT;
          end
        end
        S_AGE_INC: begin
          prio_r[t_r] <= t_prio + 5'd1;
          ret_r       <= S_AGE_NEXT;
          state_r     <= S_PUSH0;
        end
        S_AGE_NEXT: begin
          if (t_r == pfts_pkg::TaskW'(pfts_pkg::MaxTasks - 1)) begin
            t_r     <= cur_task_r;
            state_r <= S_QUANT;
          end else begin
            t_r     <= t_r + 4'd1;
            state_r <= S_AGE_T;
          end
        end
        // quantum accounting for the running task
        S_QUANT: begin
          if (!cur_valid_r) begin
            state_r <= S_PICK_LV;
          end else if (t_prio == pfts_pkg::PrioMax) begin
            sw_r    <= !same_task;
            state_r <= S_REPORT;
          end else begin
            slice_r[t_r] <= slice_dec;
            if (slice_dec != '0) begin
              sw_r    <= !same_task;
              state_r <= S_REPORT;
            end else begin
              if (t_boost != '0) begin
                boost_r[t_r] <= t_boost - 8'd1;
                if (t_boost == 8'd1) prio_r[t_r] <= t_base;
              end else if (t_prio > t_base) begin
                prio_r[t_r] <= decay_prio;
              end
              state_r <= S_QUANT2;
            end
          end
        end
        S_QUANT2: begin
          slice_r[t_r] <= pfts_pkg::band_slice(t_prio);
          cur_valid_r  <= 1'b0;
          ret_r        <= S_PICK_LV;
          state_r      <= S_PUSH0;
        end
        // pick the head of the highest non-empty level, or report idle when all levels are empty
        S_PICK_LV: begin
          if (ready_mask_r == '0) begin
            cur_valid_r <= 1'b0;
            cur_task_r  <= '0;
            sw_r        <= prev_valid_r;
            state_r     <= S_REPORT;
          end else begin
            lv_r    <= pfts_pkg::PrioMax;
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          if (lv_bit) state_r <= S_PICK2;
          else lv_r <= lv_r - 5'd1;
        end
        S_PICK2: begin
          t_r     <= lv_head;
          ret_r   <= S_PICK3;
          state_r <= S_PULL0;
        end
        S_PICK3: begin
          cur_task_r  <= t_r;
          cur_valid_r <= 1'b1;
          last_r[t_r] <= tick_r;
          if (t_slice == '0) slice_r[t_r] <= pfts_pkg::band_slice(t_prio);
          sw_r        <= !same_task;
          state_r     <= S_REPORT;
        end
        S_REPORT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_task_r  <= cur_valid_r ? cur_task_r : '0;
            out_idle_r  <= !cur_valid_r;
            out_sw_r    <= sw_r;
            out_prio_r  <= cur_valid_r ? t_prio : '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // the running task is never also waiting in a queue
  a_run_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cur_valid_r) |-> !ready_r[cur_task_r])
    else $error("running task still marked ready");

  // some task is queued exactly when some level is non-empty
  a_mask_matches_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((ready_mask_r != '0) == (ready_r != '0)))
    else $error("ready mask out of step with ready flags");

  // a result is only loaded from the report step
  a_out_from_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == S_REPORT))
    else $error("result appeared outside the report step");

endmodule

@@ rtl/core/pfts_cfg.sv @@
// configuration register file of the scheduler
module pfts_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pfts_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pfts_pkg::CfgDataW-1:0]  cfg_data,
  output pfts_pkg::cfg_t                 cfg
);

  pfts_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interval <= 8'd10;
      cfg_r.starve   <= 16'd40;
      cfg_r.cap      <= 5'd23;
      cfg_r.span     <= 5'd8;
      cfg_r.decay    <= 5'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        pfts_pkg::CFG_AGING_INTERVAL: cfg_r.interval <= cfg_data[7:0];
        pfts_pkg::CFG_AGING_STARVE:   cfg_r.starve   <= cfg_data;
        pfts_pkg::CFG_AGING_CAP:      cfg_r.cap      <= cfg_data[4:0];
        pfts_pkg::CFG_AGING_SPAN:     cfg_r.span     <= cfg_data[4:0];
        pfts_pkg::CFG_DECAY_STEP:     cfg_r.decay    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

endmodule
